[design/pszs_pkg.sv]
package pszs_pkg;

   localparam int WINDOW = 30;
   localparam int PTR_W = 5;
   localparam int RATIO_W = 24;
   localparam int SUM_W = 29;
   localparam int SQ_W = 53;

   localparam logic [1:0] ACT_HOLD = 2'd0;
   localparam logic [1:0] ACT_BUY  = 2'd1;
   localparam logic [1:0] ACT_SELL = 2'd2;
   localparam logic [1:0] ACT_LIQ  = 2'd3;

   localparam logic CSR_ENTER = 1'b0;
   localparam logic CSR_EXIT  = 1'b1;

   localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

   // handshake between the sequencer and the shared divider
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

[design/pair_spread_zscore_signal_core.sv]
// pair spread z-score signal core
// work per request: a 64-step ratio division (skipped for a zero price b), numerator and variance,
//   then with a full window a 32-step square root and, with a nonzero deviation, a 64-step z division
// flow: one request in flight; the pace is set by the shared bit-serial divider, and a stalled
//   result holds the next result back in ST_OUT
// reset: synchronous active high; clears window count, sums and positions, restores thresholds
module pair_spread_zscore_signal_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_price_a,
   input  logic [31:0] req_price_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action_a,
   output logic [1:0]  rsp_action_b,
   output logic signed [31:0] rsp_zscore,
   output logic        rsp_warmed_up,
   output logic        rsp_ratio_saturated,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import pszs_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RDIV  = 4'd1;  // ratio division running
   localparam logic [3:0] ST_STAT  = 4'd2;  // numerator and variance
   localparam logic [3:0] ST_SQRT  = 4'd3;  // integer square root
   localparam logic [3:0] ST_ZDIV  = 4'd4;  // z division running
   localparam logic [3:0] ST_RULE  = 4'd5;  // thresholds, window update, result out
   localparam logic [3:0] ST_OUT   = 4'd6;  // wait for result slot
   localparam logic [3:0] ST_VAR2  = 4'd7;  // variance second stage

   logic [3:0]  state_ff, state_in;

   // configuration
   logic signed [31:0] enter_ff, exit_ff;

   // window state
   logic [PTR_W-1:0]   wptr_ff;
   logic [PTR_W-1:0]   fill_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic               short_ff, long_ff;

   // per-request working registers
   logic [31:0]        a_ff, b_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic               sat_ff;
   logic               warm_ff;
   logic signed [34:0] num_ff;      // W*r - S
   logic [63:0]        wq_ff;       // W*Q
   logic [63:0]        var_ff;      // radicand, consumed during sqrt
   logic [31:0]        root_ff;
   logic [5:0]         sq_cnt_ff;
   logic [33:0]        sq_rem_ff;
   logic signed [32:0] z_ff;
   logic               div_sent_ff;

   // result register
   logic               rsp_valid_ff;
   logic [1:0]         act_a_ff, act_b_ff;
   logic signed [31:0] zout_ff;
   logic               warm_out_ff, sat_out_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [RATIO_W-1:0] old_ratio;

   pszs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic ram_we;
   pszs_ratio_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data (ratio_ff),
      .rd_addr (wptr_ff),
      .rd_data (old_ratio)
   );

   // request is accepted only when idle
   assign req_stall = (state_ff != ST_IDLE);
   wire req_take = req_valid && !req_stall;

   // square root step: two radicand bits per cycle, restoring form
   logic [33:0] sq_trial;
   logic [33:0] sq_rem_next;
   logic [31:0] root_next;
   always_comb begin
      sq_trial    = {sq_rem_ff[31:0], var_ff[63:62]};
      sq_rem_next = sq_trial;
      root_next   = {root_ff[30:0], 1'b0};
      if (sq_trial >= {root_ff, 2'b01}) begin
         sq_rem_next = sq_trial - {root_ff, 2'b01};
         root_next   = {root_ff[30:0], 1'b1};
      end
   end

   // threshold rules on the final z
   logic [1:0] rule_a, rule_b;
   logic       rule_short, rule_long;
   logic       no_rule;
   logic signed [32:0] enter_x, exit_x;
   always_comb begin
      enter_x    = 33'(enter_ff);
      exit_x     = 33'(exit_ff);
      rule_a     = ACT_HOLD;
      rule_b     = ACT_HOLD;
      rule_short = short_ff;
      rule_long  = long_ff;
      no_rule    = warm_ff && (root_ff == '0) && (num_ff == '0);
      if (!no_rule) begin
         if (z_ff > enter_x) begin
            rule_a = ACT_SELL; rule_b = ACT_BUY; rule_short = 1'b1;
         end
         if (rule_short && z_ff <= exit_x) begin
            rule_a = ACT_LIQ; rule_b = ACT_LIQ; rule_short = 1'b0;
         end
         if (z_ff < -enter_x) begin
            rule_a = ACT_BUY; rule_b = ACT_SELL; rule_long = 1'b1;
         end
         if (rule_long && z_ff >= -exit_x) begin
            rule_a = ACT_LIQ; rule_b = ACT_LIQ; rule_long = 1'b0;
         end
      end
   end

   // z from the divider quotient with sign and saturation
   logic [63:0] num_mag;
   logic signed [32:0] z_from_q;
   always_comb begin
      num_mag = num_ff[34] ? 64'(-num_ff) : 64'(num_ff);
      if (!num_ff[34]) begin
         z_from_q = (div_rsp.quotient > 64'd2147483647) ? 33'sd2147483647
                    : 33'(div_rsp.quotient[31:0]);
      end else begin
         z_from_q = (div_rsp.quotient > 64'd2147483648) ? -33'sd2147483648
                    : -33'($signed({1'b0, div_rsp.quotient[31:0]}));
      end
   end

   // ratio from the divider quotient
   wire ratio_ovf = (div_rsp.quotient[63:RATIO_W] != '0);

   // window update terms
   wire [SUM_W-1:0] old_ext  = warm_ff ? SUM_W'(old_ratio) : '0;
   wire [SQ_W-1:0]  old_sq   = warm_ff ? SQ_W'(48'(old_ratio) * 48'(old_ratio)) : '0;
   wire [SQ_W-1:0]  new_sq   = SQ_W'(48'(ratio_ff) * 48'(ratio_ff));

   logic [57:0] ss_prod;  // S*S, 29x29
   assign ss_prod = 58'(sum_ff) * 58'(sum_ff);

   always_comb begin
      state_in = state_ff;
      div_req  = '0;
      ram_we   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_RDIV;
         end
         ST_RDIV: begin
            if (!div_sent_ff) begin
               div_req.start    = (b_ff != '0);
               div_req.dividend = {16'd0, a_ff, 16'd0};
               div_req.divisor  = {32'd0, b_ff};
               if (b_ff == '0) state_in = ST_STAT;
            end else if (div_rsp.done) begin
               state_in = ST_STAT;
            end
         end
         ST_STAT: state_in = ST_VAR2;
         ST_VAR2: state_in = warm_ff ? ST_SQRT : ST_OUT;
         ST_SQRT: begin
            if (sq_cnt_ff == 6'd31) state_in = ST_ZDIV;
         end
         ST_ZDIV: begin
            if (root_ff == '0) begin
               state_in = ST_OUT;
            end else if (!div_sent_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = {num_mag[47:0], 16'd0};
               div_req.divisor  = {32'd0, root_ff};
            end else if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         // result register is free here, so the new result can be loaded
         ST_RULE: begin
            ram_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_RULE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enter_ff     <= 32'sd131072;
         exit_ff      <= '0;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         short_ff     <= 1'b0;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_sent_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            if (csr_index == CSR_ENTER) enter_ff <= csr_data;
            else                        exit_ff  <= csr_data;
         end
         if (state_ff == ST_RULE) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         div_sent_ff <= (state_ff != state_in) ? 1'b0 : (div_sent_ff | div_req.start);

         unique case (state_ff)
            ST_RULE: begin
               short_ff <= rule_short;
               long_ff  <= rule_long;
               sum_ff   <= sum_ff - old_ext + SUM_W'(ratio_ff);
               sq_ff    <= sq_ff - old_sq + new_sq;
               if (!warm_ff) fill_ff <= fill_ff + 1'b1;
               wptr_ff  <= (wptr_ff == PTR_W'(WINDOW - 1)) ? '0 : wptr_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            a_ff    <= req_price_a;
            b_ff    <= req_price_b;
            warm_ff <= (fill_ff >= PTR_W'(WINDOW));
            z_ff    <= '0;
            root_ff <= '0;
            num_ff  <= '0;
         end
         ST_RDIV: begin
            if (!div_sent_ff && b_ff == '0) begin
               ratio_ff <= RATIO_MAX;
               sat_ff   <= 1'b1;
            end else if (div_rsp.done) begin
               ratio_ff <= ratio_ovf ? RATIO_MAX : div_rsp.quotient[RATIO_W-1:0];
               sat_ff   <= ratio_ovf;
            end
         end
         ST_STAT: begin
            num_ff <= 35'($signed({1'b0, 32'(ratio_ff) * 32'(WINDOW)}))
                      - 35'($signed({1'b0, sum_ff}));
            wq_ff  <= 64'(sq_ff) * 64'(WINDOW);
         end
         ST_VAR2: begin
            var_ff    <= wq_ff - 64'(ss_prod);
            sq_cnt_ff <= '0;
            sq_rem_ff <= '0;
            root_ff   <= '0;
         end
         ST_SQRT: begin
            sq_rem_ff <= sq_rem_next;
            root_ff   <= root_next;
            var_ff    <= {var_ff[61:0], 2'b00};
            sq_cnt_ff <= sq_cnt_ff + 6'd1;
         end
         ST_ZDIV: begin
            if (root_ff == '0) begin
               z_ff <= num_ff[34] ? -33'sd2147483648
                     : (num_ff == '0 ? 33'sd0 : 33'sd2147483647);
            end else if (div_rsp.done) begin
               z_ff <= z_from_q;
            end
         end
         ST_RULE: begin
            act_a_ff    <= rule_a;
            act_b_ff    <= rule_b;
            zout_ff     <= z_ff[31:0];
            warm_out_ff <= warm_ff;
            sat_out_ff  <= sat_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action_a        = act_a_ff;
   assign rsp_action_b        = act_b_ff;
   assign rsp_zscore          = zout_ff;
   assign rsp_warmed_up       = warm_out_ff;
   assign rsp_ratio_saturated = sat_out_ff;
endmodule

[design/pszs_divider.sv]
module pszs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pszs_pkg::div_req_type div_req,
   output pszs_pkg::div_rsp_type div_rsp
);
   import pszs_pkg::*;

   // restoring divider, one quotient bit per cycle
   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[63:0], quo_ff[63]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

[design/pszs_ratio_ram.sv]
module pszs_ratio_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [pszs_pkg::PTR_W-1:0]    wr_addr,
   input  logic [pszs_pkg::RATIO_W-1:0]  wr_data,
   input  logic [pszs_pkg::PTR_W-1:0]    rd_addr,
   output logic [pszs_pkg::RATIO_W-1:0]  rd_data
);
   import pszs_pkg::*;

   logic [RATIO_W-1:0] mem [WINDOW];
   logic [RATIO_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
